FILE: sv/adc_frame_deframer_calibrator_top_macros.svh
// assertion macros shared by the deframer/calibrator modules
// expects aclk and aresetn in the scope of each use
`ifndef ADC_FRAME_DEFRAMER_CALIBRATOR_TOP_MACROS_SVH
`define ADC_FRAME_DEFRAMER_CALIBRATOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define AFDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define AFDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/afdc_pkg.sv
// shared types, codes and constants of the adc frame deframer/calibrator
// no dependencies
package afdc_pkg;

    localparam int CHANNELS_DEF         = 64;
    localparam int PE_FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [31:0] HG_MASK    = 32'h0068_0000;
    localparam logic [11:0] COUNT_MASK = 12'h0fff;
    localparam int          HEADER_BIT = 27;
    localparam int          CHAN_LSB   = 13;
    localparam int          OTR_BIT    = 12;

    localparam logic [11:0] PED_RESET  = 12'd820;
    localparam logic [11:0] GAIN_RESET = 12'd50;
    localparam logic [20:0] PE_MAX     = 21'd1048575;

    // result kinds
    localparam logic [1:0] KIND_TIME   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // configuration register indexes
    localparam logic REG_PEDESTAL = 1'b0;
    localparam logic REG_GAIN     = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TIME,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        OP_TIME,
        OP_ERROR,
        OP_DATA
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_DIV,
        B_OUT
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic        store;
        logic        burst;
    } cmd_t;

endpackage

FILE: sv/afdc_cmd_fifo.sv
// short command queue between the front and back of the deframer
// depends on afdc_pkg (cmd_t, QUEUE_DEPTH)
module afdc_cmd_fifo #(
    parameter int DEPTH = afdc_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  afdc_pkg::cmd_t push_cmd,
    output logic           not_full,
    input  logic           pop,
    output afdc_pkg::cmd_t pop_cmd,
    output logic           not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    afdc_pkg::cmd_t    mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/afdc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module afdc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

endmodule

FILE: sv/afdc_front.sv
// front end: frame tracking and word classification into queue commands
// depends on afdc_pkg (phase_t, op_t, cmd_t, field constants)
module afdc_front #(
    parameter int CHANNELS = afdc_pkg::CHANNELS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [31:0]    s_input_word,
    input  logic           q_not_full,
    output logic           q_push,
    output afdc_pkg::cmd_t q_cmd
);

    afdc_pkg::phase_t phase_reg, phase_next;
    logic [11:0]      words_left_reg, words_left_next;
    logic             accept;
    logic             want;
    logic [5:0]       ch;
    logic             high_gain;
    logic             store;
    logic             burst;

    assign s_ready   = q_not_full;
    assign accept    = s_valid && s_ready;
    assign ch        = s_input_word[afdc_pkg::CHAN_LSB +: 6];
    assign high_gain = ((s_input_word & afdc_pkg::HG_MASK) == '0);
    assign store     = !s_input_word[afdc_pkg::OTR_BIT] && ({1'b0, ch} < 7'(CHANNELS));
    assign burst     = (ch == 6'(CHANNELS - 1));

    always_comb begin
        phase_next      = phase_reg;
        words_left_next = words_left_reg;
        want            = 1'b0;
        q_cmd.op        = afdc_pkg::OP_DATA;
        q_cmd.word      = s_input_word;
        q_cmd.store     = store;
        q_cmd.burst     = burst;
        case (phase_reg)
            afdc_pkg::PH_HEADER: begin
                if (!s_input_word[afdc_pkg::HEADER_BIT]) begin
                    want     = 1'b1;
                    q_cmd.op = afdc_pkg::OP_ERROR;
                end else begin
                    words_left_next = s_input_word[11:0] & afdc_pkg::COUNT_MASK;
                    phase_next      = afdc_pkg::PH_TIME;
                end
            end
            afdc_pkg::PH_TIME: begin
                want       = 1'b1;
                q_cmd.op   = afdc_pkg::OP_TIME;
                phase_next = (words_left_reg != '0) ? afdc_pkg::PH_DATA : afdc_pkg::PH_HEADER;
            end
            afdc_pkg::PH_DATA: begin
                words_left_next = words_left_reg - 1'b1;
                if (words_left_next == '0) begin
                    phase_next = afdc_pkg::PH_HEADER;
                end
                // low-gain and other data words fall through with no command
                want = high_gain && (store || burst);
            end
            default: begin
                phase_next = afdc_pkg::PH_HEADER;
            end
        endcase
    end

    assign q_push = accept && want;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= afdc_pkg::PH_HEADER;
            words_left_reg <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule

FILE: sv/afdc_back.sv
// back end: channel store, calibration divider and result register
// depends on afdc_pkg, afdc_ram and the assertion macro header
`include "adc_frame_deframer_calibrator_top_macros.svh"

module afdc_back #(
    parameter int CHANNELS         = afdc_pkg::CHANNELS_DEF,
    parameter int PE_FRACTION_BITS = afdc_pkg::PE_FRACTION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  afdc_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    input  logic [11:0]        pedestal,
    input  logic [11:0]        gain_counts,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [31:0]        m_frame_word,
    output logic [5:0]         m_channel,
    output logic [11:0]        m_adc_value,
    output logic signed [20:0] m_photoelectrons,
    output logic               m_last
);

    localparam int CW  = $clog2(CHANNELS);
    localparam int NW  = 12 + PE_FRACTION_BITS;
    localparam int DCW = $clog2(NW + 1);
    localparam int QW  = (NW > 21) ? NW : 21;

    afdc_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CHANNELS-1:0] vld_reg, vld_next;
    logic                rdv_reg, rdv_next;
    logic [11:0]         adc_reg, adc_next;
    logic                neg_reg, neg_next;
    logic [11:0]         rem_reg, rem_next;
    logic [NW-1:0]       quot_reg, quot_next;
    logic [DCW-1:0]      cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [31:0]         out_word_reg, out_word_next;
    logic [5:0]          out_ch_reg, out_ch_next;
    logic [11:0]         out_adc_reg, out_adc_next;
    logic [20:0]         out_pe_reg, out_pe_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [CW-1:0]       cmd_addr;
    logic                ram_we;
    logic                ram_re;
    logic [11:0]         ram_rdata;
    logic [11:0]         divisor;
    logic [11:0]         value;
    logic [12:0]         diff;
    logic [12:0]         diff_abs;
    logic [12:0]         rem_sh;
    logic                ge;
    logic [20:0]         pe_mag;

    assign out_free = !out_valid_reg || m_ready;
    assign cmd_addr = q_cmd.word[afdc_pkg::CHAN_LSB +: CW];
    assign divisor  = (gain_counts == '0) ? 12'd1 : gain_counts;

    // a never-written channel reads as zero
    assign value    = rdv_reg ? ram_rdata : 12'd0;
    assign diff     = {1'b0, value} - {1'b0, pedestal};
    assign diff_abs = diff[12] ? -diff : diff;

    // restoring division step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quot_reg[NW-1]};
    assign ge       = (rem_sh >= {1'b0, divisor});
    assign pe_mag   = (QW'(quot_reg) > QW'(afdc_pkg::PE_MAX)) ? afdc_pkg::PE_MAX
                                                              : 21'(quot_reg);

    afdc_ram #(
        .WIDTH (12),
        .DEPTH (CHANNELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd_addr),
        .wdata (q_cmd.word[11:0]),
        .re    (ram_re),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        vld_next       = vld_reg;
        rdv_next       = rdv_reg;
        adc_next       = adc_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_word_next  = out_word_reg;
        out_ch_next    = out_ch_reg;
        out_adc_next   = out_adc_reg;
        out_pe_next    = out_pe_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            afdc_pkg::B_IDLE: begin
                if (q_not_empty) begin
                    if (q_cmd.op == afdc_pkg::OP_DATA) begin
                        q_pop  = 1'b1;
                        ram_we = q_cmd.store;
                        if (q_cmd.store) begin
                            vld_next[cmd_addr] = 1'b1;
                        end
                        if (q_cmd.burst) begin
                            k_next     = '0;
                            state_next = afdc_pkg::B_READ;
                        end
                    end else if (out_free) begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = (q_cmd.op == afdc_pkg::OP_TIME) ? afdc_pkg::KIND_TIME
                                                                         : afdc_pkg::KIND_ERROR;
                        out_word_next  = q_cmd.word;
                        out_ch_next    = '0;
                        out_adc_next   = '0;
                        out_pe_next    = '0;
                        out_last_next  = 1'b1;
                    end
                end
            end
            afdc_pkg::B_READ: begin
                ram_re     = 1'b1;
                rdv_next   = vld_reg[k_reg];
                state_next = afdc_pkg::B_LOAD;
            end
            afdc_pkg::B_LOAD: begin
                adc_next   = value;
                neg_next   = diff[12];
                rem_next   = '0;
                quot_next  = NW'(diff_abs[11:0]) << PE_FRACTION_BITS;
                cnt_next   = DCW'(NW);
                state_next = afdc_pkg::B_DIV;
            end
            afdc_pkg::B_DIV: begin
                rem_next  = ge ? 12'(rem_sh - {1'b0, divisor}) : rem_sh[11:0];
                quot_next = {quot_reg[NW-2:0], ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == DCW'(1)) begin
                    state_next = afdc_pkg::B_OUT;
                end
            end
            afdc_pkg::B_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = afdc_pkg::KIND_RECORD;
                    out_word_next  = '0;
                    out_ch_next    = 6'(k_reg);
                    out_adc_next   = adc_reg;
                    out_pe_next    = neg_reg ? -pe_mag : pe_mag;
                    out_last_next  = (k_reg == CW'(CHANNELS - 1));
                    if (k_reg == CW'(CHANNELS - 1)) begin
                        state_next = afdc_pkg::B_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = afdc_pkg::B_READ;
                    end
                end
            end
            default: begin
                state_next = afdc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= afdc_pkg::B_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rdv_reg      <= rdv_next;
        adc_reg      <= adc_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        out_kind_reg <= out_kind_next;
        out_word_reg <= out_word_next;
        out_ch_reg   <= out_ch_next;
        out_adc_reg  <= out_adc_next;
        out_pe_reg   <= out_pe_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_frame_word     = out_word_reg;
    assign m_channel        = out_ch_reg;
    assign m_adc_value      = out_adc_reg;
    assign m_photoelectrons = out_pe_reg;
    assign m_last           = out_last_reg;

    `AFDC_ASSERT_NOW(a_single_is_last, out_valid_reg && (out_kind_reg != afdc_pkg::KIND_RECORD), out_last_reg, "time or error word without last")
    `AFDC_ASSERT_NOW(a_rem_below_div, state_reg == afdc_pkg::B_DIV, rem_reg < divisor, "divider remainder not below divisor")
    `AFDC_ASSERT_NEXT(a_out_stall_holds, (state_reg == afdc_pkg::B_OUT) && out_valid_reg && !m_ready, state_reg == afdc_pkg::B_OUT, "record issued over a stalled word")
    `AFDC_ASSERT_NOW(a_pop_only_idle, q_pop, state_reg == afdc_pkg::B_IDLE, "queue popped during a burst")

endmodule

FILE: sv/adc_frame_deframer_calibrator_top.sv
// adc frame deframer and calibrator, top level
// depends on afdc_pkg, afdc_front, afdc_cmd_fifo, afdc_back
// Usage:
//   s_* is a valid/ready stream of 32-bit words: header, time word, then the
//   number of data words given by the header's low 12 bits. m_* carries
//   result words: a time word or a frame error (one word each, last set)
//   or, on a high-gain word for the last channel, a burst of CHANNELS
//   channel records with calibrated photoelectrons, last on the final one.
//   cfg_we/cfg_index/cfg_wdata write pedestal (0) and gain_counts (1), idle only.
// Timing:
//   the front takes one word per cycle while the four-entry command queue
//   has room. With the back end idle, a time or error word is written to the
//   command queue and then to the result register that drives m_valid. Each
//   channel record goes through the store read, the divider load, the
//   one-bit-per-cycle restoring divider over 12 + PE_FRACTION_BITS bits and
//   the output state; the queue is not popped until the burst ends.
// Reset and stalls:
//   reset returns the frame tracker to header hunt, restores the register
//   defaults and marks every stored channel as zero at once. A stalled
//   m_ready holds the result register; the queue then fills and drops s_ready.
module adc_frame_deframer_calibrator_top #(
    parameter int CHANNELS         = afdc_pkg::CHANNELS_DEF,
    parameter int PE_FRACTION_BITS = afdc_pkg::PE_FRACTION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_input_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [31:0]        m_frame_word,
    output logic [5:0]         m_channel,
    output logic [11:0]        m_adc_value,
    output logic signed [20:0] m_photoelectrons,
    output logic               m_last,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [11:0]        cfg_wdata
);

    logic [11:0]    pedestal_reg, pedestal_next;
    logic [11:0]    gain_reg, gain_next;
    logic           q_push;
    logic           q_pop;
    logic           q_not_full;
    logic           q_not_empty;
    afdc_pkg::cmd_t push_cmd;
    afdc_pkg::cmd_t pop_cmd;

    always_comb begin
        pedestal_next = pedestal_reg;
        gain_next     = gain_reg;
        if (cfg_we) begin
            case (cfg_index)
                afdc_pkg::REG_PEDESTAL: pedestal_next = cfg_wdata & afdc_pkg::COUNT_MASK;
                afdc_pkg::REG_GAIN:     gain_next     = cfg_wdata & afdc_pkg::COUNT_MASK;
                default:                pedestal_next = pedestal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pedestal_reg <= afdc_pkg::PED_RESET;
            gain_reg     <= afdc_pkg::GAIN_RESET;
        end else begin
            pedestal_reg <= pedestal_next;
            gain_reg     <= gain_next;
        end
    end

    afdc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_input_word (s_input_word),
        .q_not_full   (q_not_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    afdc_cmd_fifo #(
        .DEPTH (afdc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_not_empty)
    );

    afdc_back #(
        .CHANNELS         (CHANNELS),
        .PE_FRACTION_BITS (PE_FRACTION_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_not_empty      (q_not_empty),
        .q_cmd            (pop_cmd),
        .q_pop            (q_pop),
        .pedestal         (pedestal_reg),
        .gain_counts      (gain_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_frame_word     (m_frame_word),
        .m_channel        (m_channel),
        .m_adc_value      (m_adc_value),
        .m_photoelectrons (m_photoelectrons),
        .m_last           (m_last)
    );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for adc_frame_deframer_calibrator_top: directed frames, register
// sweeps, back-pressure and random word streams, checked against an in-bench predictor
// depends on afdc_pkg and the block's rtl
module testbench;

    typedef struct {
        logic [1:0]         kind;
        logic [31:0]        frame_word;
        logic [5:0]         channel;
        logic [11:0]        adc_value;
        logic signed [20:0] pe;
        logic               last;
    } cal_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_input_word;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kind;
    logic [31:0]        m_frame_word;
    logic [5:0]         m_channel;
    logic [11:0]        m_adc_value;
    logic signed [20:0] m_photoelectrons;
    logic               m_last;
    logic               cfg_we;
    logic               cfg_index;
    logic [11:0]        cfg_wdata;

    // predictor state
    afdc_pkg::phase_t hunt_phase;
    logic [11:0]      words_due;
    logic [11:0]      chan_value [afdc_pkg::CHANNELS_DEF];
    logic [11:0]      ped_reg;
    logic [11:0]      gain_reg;
    cal_result_t      pending_results [$];

    int mismatches   = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int bursts_seen  = 0;
    bit gaps_on;
    bit stalls_on;
    bit hold_req;
    int hold_cycles;

    adc_frame_deframer_calibrator_top dut (.*);

    always #4 aclk = ~aclk;

    function automatic logic signed [20:0] calibrate_pe(logic [11:0] value);
        int diff;
        int divisor;
        int quot;
        diff    = int'(value) - int'(ped_reg);
        divisor = (gain_reg == '0) ? 1 : int'(gain_reg);
        quot    = (diff * (1 << afdc_pkg::PE_FRACTION_BITS_DEF)) / divisor;
        if (quot > int'(afdc_pkg::PE_MAX)) quot = int'(afdc_pkg::PE_MAX);
        if (quot < -int'(afdc_pkg::PE_MAX)) quot = -int'(afdc_pkg::PE_MAX);
        return quot[20:0];
    endfunction

    function automatic void expect_result(logic [1:0] kind, logic [31:0] word,
                                          logic [5:0] ch, logic [11:0] adc,
                                          logic signed [20:0] pe, logic last);
        cal_result_t r;
        r.kind       = kind;
        r.frame_word = word;
        r.channel    = ch;
        r.adc_value  = adc;
        r.pe         = pe;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_word(logic [31:0] w);
        logic [5:0] ch;
        case (hunt_phase)
            afdc_pkg::PH_HEADER: begin
                if (!w[afdc_pkg::HEADER_BIT]) begin
                    expect_result(afdc_pkg::KIND_ERROR, w, '0, '0, '0, 1'b1);
                end else begin
                    words_due  = w[11:0] & afdc_pkg::COUNT_MASK;
                    hunt_phase = afdc_pkg::PH_TIME;
                end
            end
            afdc_pkg::PH_TIME: begin
                hunt_phase = (words_due != '0) ? afdc_pkg::PH_DATA : afdc_pkg::PH_HEADER;
                expect_result(afdc_pkg::KIND_TIME, w, '0, '0, '0, 1'b1);
            end
            default: begin
                words_due = words_due - 1'b1;
                if (words_due == '0) hunt_phase = afdc_pkg::PH_HEADER;
                if ((w & afdc_pkg::HG_MASK) == '0) begin
                    ch = w[afdc_pkg::CHAN_LSB +: 6];
                    if (!w[afdc_pkg::OTR_BIT]) chan_value[ch] = w[11:0];
                    // last channel dumps the whole store
                    if (ch == 6'(afdc_pkg::CHANNELS_DEF - 1)) begin
                        for (int k = 0; k < afdc_pkg::CHANNELS_DEF; k++)
                            expect_result(afdc_pkg::KIND_RECORD, '0, 6'(k), chan_value[k],
                                          calibrate_pe(chan_value[k]),
                                          k == afdc_pkg::CHANNELS_DEF - 1);
                    end
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_seen, name, got, want));
    endtask

    always @(posedge aclk) begin : check_results
        cal_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected word, kind %0d", m_kind));
            end else begin
                want = pending_results.pop_front();
                check_field("kind", m_kind, want.kind);
                check_field("frame_word", m_frame_word, want.frame_word);
                check_field("channel", m_channel, want.channel);
                check_field("adc_value", m_adc_value, want.adc_value);
                check_field("photoelectrons", m_photoelectrons, want.pe);
                check_field("last", m_last, want.last);
                if (m_kind == afdc_pkg::KIND_RECORD && m_last) bursts_seen++;
            end
            results_seen++;
        end
    end

    initial begin : drive_ready
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // entered and left at a falling edge; valid stays up for a following word
    task automatic send_word(logic [31:0] w);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_input_word = w;
        s_valid      = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        // a store-only word may still be in the back end
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == afdc_pkg::REG_PEDESTAL) ped_reg = value;
        else gain_reg = value;
    endtask

    function automatic logic [31:0] hg_word(logic [5:0] ch, logic otr, logic [11:0] value);
        logic [31:0] w;
        w                          = $urandom & ~afdc_pkg::HG_MASK;
        w[afdc_pkg::CHAN_LSB +: 6] = ch;
        w[afdc_pkg::OTR_BIT]       = otr;
        w[11:0]                    = value;
        return w;
    endfunction

    task automatic send_random_frame(int max_count, bit allow_burst);
        logic [11:0] count;
        logic [31:0] w;
        int          pick;
        count = 12'($urandom_range(0, max_count));
        send_word(($urandom & ~32'h0fff) | (32'h1 << afdc_pkg::HEADER_BIT) | count);
        send_word($urandom);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                w = hg_word(6'($urandom_range(0, afdc_pkg::CHANNELS_DEF - 2)),
                            $urandom_range(0, 3) == 0, 12'($urandom));
            end else if (pick < 9 || !allow_burst) begin
                w = $urandom;
                if ((w & afdc_pkg::HG_MASK) == '0) w[19] = 1'b1;
            end else begin
                w = hg_word(6'(afdc_pkg::CHANNELS_DEF - 1), $urandom_range(0, 1),
                            12'($urandom));
            end
            send_word(w);
        end
    endtask

    task automatic send_burst_frame(logic [11:0] value, logic otr);
        send_word(($urandom & ~32'h0fff) | (32'h1 << afdc_pkg::HEADER_BIT) | 32'd1);
        send_word($urandom);
        send_word(hg_word(6'(afdc_pkg::CHANNELS_DEF - 1), otr, value));
    endtask

    task automatic test_directed_frames();
        send_word(32'h0000_0000);                  // header without the header bit
        send_word(32'hf7ff_ffff);
        send_word(32'h0800_0000);                  // empty frame, header follows the time word
        send_word(32'hffff_ffff);
        send_word(32'h0800_0005);
        send_word(32'h0000_0000);
        send_word(hg_word(6'd0, 1'b0, 12'hfff));
        send_word(hg_word(6'd5, 1'b1, 12'h123));   // out of range, not stored
        send_word(32'hffff_ffff);                  // not high gain, dropped
        send_word(hg_word(6'd10, 1'b0, 12'h000));
        send_word(hg_word(6'(afdc_pkg::CHANNELS_DEF - 1), 1'b0, 12'h800));
        send_burst_frame(12'habc, 1'b1);           // out of range on last channel still dumps
        wait_idle();
    endtask

    task automatic test_register_sweep();
        logic [11:0] ped;
        logic [11:0] gain;
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: begin ped = 12'd0;    gain = 12'd1;    end
                1: begin ped = 12'd4095; gain = 12'd1;    end
                2: begin ped = 12'd4095; gain = 12'd4095; end
                3: begin ped = 12'd0;    gain = 12'd0;    end   // zero gain divides by one
                default: begin
                    ped  = 12'($urandom);
                    gain = 12'($urandom_range(1, 4095));
                end
            endcase
            write_reg(afdc_pkg::REG_PEDESTAL, ped);
            write_reg(afdc_pkg::REG_GAIN, gain);
            send_random_frame(4, 1'b0);
            send_burst_frame(12'($urandom), 1'b0);
            wait_idle();
        end
        write_reg(afdc_pkg::REG_PEDESTAL, 12'd200);
        write_reg(afdc_pkg::REG_GAIN, 12'd37);
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        hold_req    = 1'b1;
        send_burst_frame(12'($urandom), 1'b0);
        // error words pile up behind the stalled burst until input ready drops
        for (int i = 0; i < 12; i++)
            send_word($urandom & ~(32'h1 << afdc_pkg::HEADER_BIT));
        wait_idle();
    endtask

    task automatic test_random_stream();
        int start;
        start = words_sent;
        while (words_sent - start < 150) begin
            if ($urandom_range(0, 6) == 0)
                send_word($urandom & ~(32'h1 << afdc_pkg::HEADER_BIT));
            else
                send_random_frame(6, 1'b1);
        end
        wait_idle();
        write_reg(afdc_pkg::REG_PEDESTAL, 12'($urandom));
        write_reg(afdc_pkg::REG_GAIN, 12'($urandom_range(1, 4095)));
    endtask

    task automatic test_steady_stream();
        int start;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        start     = words_sent;
        while (words_sent - start < 40)
            send_random_frame(6, 1'b1);
        wait_idle();
    endtask

    initial begin
        s_valid      = 1'b0;
        s_input_word = '0;
        cfg_we       = 1'b0;
        cfg_index    = afdc_pkg::REG_PEDESTAL;
        cfg_wdata    = '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        hold_req     = 1'b0;
        hold_cycles  = 0;
        hunt_phase   = afdc_pkg::PH_HEADER;
        words_due    = '0;
        foreach (chan_value[i]) chan_value[i] = '0;
        ped_reg      = afdc_pkg::PED_RESET;
        gain_reg     = afdc_pkg::GAIN_RESET;
        aresetn      = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_frames();
        test_register_sweep();
        test_backpressure();
        test_random_stream();
        test_steady_stream();

        $display("covered %0d input words, %0d result words, %0d channel bursts",
                 words_sent, results_seen, bursts_seen);
        $display("pedestal/gain extremes, zero gain, a long output stall and gap-free streaming");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("timed out with %0d results outstanding", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/afdc_pkg.sv
sv/afdc_cmd_fifo.sv
sv/afdc_ram.sv
sv/afdc_front.sv
sv/afdc_back.sv
sv/adc_frame_deframer_calibrator_top.sv
bench/testbench.sv
